FILE: src/lpt_pkg.sv
// Shared constants, command and state codes, and the scan control struct of the thread picker.
package lpt_pkg;

  // Default configuration of the picker
  localparam int unsigned THREAD_COUNT_DEF = 5;
  localparam int unsigned WEIGHT_BITS_DEF  = 8;

  // Fixed field widths
  localparam int unsigned CMD_W = 2;
  localparam int unsigned RND_W = 32;
  // Packed register fields starting at or beyond this bit read as zero
  localparam int unsigned FIELD_LIMIT = 64;

  // Register indexes of the configuration port
  localparam logic CFG_TICKETS    = 1'b0;
  localparam logic CFG_PRIORITIES = 1'b1;

  // Command codes carried in the slave-side tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_LOTTERY  = 2'd0,
    CMD_PRIORITY = 2'd1,
    CMD_RETIRE   = 2'd2,
    CMD_LOAD     = 2'd3
  } cmd_e;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_OUT
  } state_e;

  // Start request to the thread scan unit
  typedef struct packed {
    logic start;
    logic lottery;
  } scan_ctl_t;

endpackage

FILE: src/lpt_serial_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module lpt_serial_mod
  import lpt_pkg::*;
#(
  parameter int unsigned TOT_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RND_W-1:0] dividend_i,
  input  logic [TOT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [TOT_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(RND_W);

  logic [RND_W-1:0] dvd_q;
  logic [TOT_W-1:0] dvs_q;
  logic [TOT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [TOT_W:0]   rem_sh;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q, dvd_q[RND_W-1]};
    if (rem_sh >= {1'b0, dvs_q}) begin
      rem_d = TOT_W'(rem_sh - {1'b0, dvs_q});
    end else begin
      rem_d = rem_sh[TOT_W-1:0];
    end
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(RND_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shift register and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: src/lpt_thread_scan.sv
// Serial walk over the threads, one per cycle: lottery winner search or priority pick.
module lpt_thread_scan
  import lpt_pkg::*;
#(
  parameter int unsigned THREAD_COUNT = THREAD_COUNT_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF,
  parameter int unsigned TOT_W        = 11,
  parameter int unsigned CH_W         = 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  scan_ctl_t                             ctl_i,
  input  logic [THREAD_COUNT-1:0]               mask_i,
  input  logic [THREAD_COUNT-1:0][WEIGHT_BITS-1:0] weights_i,
  input  logic [TOT_W-1:0]                      ticket_i,
  output logic                                  done_o,
  output logic [CH_W-1:0]                       chosen_o
);

  localparam int unsigned IDX_W = $clog2(THREAD_COUNT);

  logic                   busy_q, done_q, lottery_q;
  logic [IDX_W-1:0]       idx_q;
  logic [TOT_W-1:0]       run_q;
  logic                   found_q;
  logic [CH_W-1:0]        win_q, last_q;
  logic [1:0]             cnt_q;
  logic [WEIGHT_BITS-1:0] best_q;
  logic                   tie_q;

  logic                   act;
  logic [WEIGHT_BITS-1:0] w;
  logic [TOT_W-1:0]       run_d;
  logic [CH_W-1:0]        thr;

  // Current thread
  assign act   = mask_i[idx_q];
  assign w     = weights_i[idx_q];
  assign run_d = run_q + TOT_W'(w);
  assign thr   = CH_W'(idx_q) + CH_W'(1);

  // Sequencing over thread indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      lottery_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q    <= 1'b1;
        lottery_q <= ctl_i.lottery;
        idx_q     <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(THREAD_COUNT - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Running sum search and priority tracking
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      run_q   <= '0;
      found_q <= 1'b0;
      win_q   <= '0;
      last_q  <= '0;
      cnt_q   <= '0;
      best_q  <= '0;
      tie_q   <= 1'b0;
    end else if (busy_q && act) begin
      if (lottery_q) begin
        run_q <= run_d;
        if (!found_q && run_d >= ticket_i) begin
          found_q <= 1'b1;
          win_q   <= thr;
        end
      end else begin
        if (cnt_q == 2'd0 || w > best_q) begin
          best_q <= w;
          win_q  <= thr;
          tie_q  <= 1'b0;
        end else if (w == best_q) begin
          tie_q <= 1'b1;
        end
        last_q <= thr;
        if (cnt_q != 2'd3) begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
    end
  end

  // Result: a lottery gives the found thread or 0; in a priority pick, with two active threads
  // a tie goes to the later one, with three or more a tie at the top picks nobody
  always_comb begin
    if (lottery_q) begin
      chosen_o = found_q ? win_q : '0;
    end else if (cnt_q == 2'd0) begin
      chosen_o = '0;
    end else if (cnt_q == 2'd2 && tie_q) begin
      chosen_o = last_q;
    end else if (tie_q) begin
      chosen_o = '0;
    end else begin
      chosen_o = win_q;
    end
  end

  assign done_o = done_q;

endmodule

FILE: src/lottery_priority_thread_picker.sv
// Top level of the lottery / priority thread picker: sequencer, thread state and ports.
// Each transaction on the slave stream carries one command and yields exactly one
// transaction on the master stream. Retire and load pass from acceptance through
// ST_OUT into the output register. A priority pick runs the scan that visits one
// thread per cycle, then ST_OUT. A lottery draw first runs the bit-serial remainder
// of random_value by the ticket total, one dividend bit per cycle, followed by the
// same one-thread-per-cycle scan; a draw with a zero ticket total skips both and
// goes straight to ST_OUT. The next command is accepted once the result sits in
// the output register, even while the master side stalls. The user must write
// ticket and priority registers only while no command is in flight; the block
// itself does not enforce this.
module lottery_priority_thread_picker
  import lpt_pkg::*;
#(
  parameter int unsigned THREAD_COUNT = THREAD_COUNT_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF,
  localparam int unsigned PACK_W  = THREAD_COUNT * WEIGHT_BITS,
  localparam int unsigned TID_W   = $clog2(THREAD_COUNT + 1),
  localparam int unsigned CH_W    = $clog2(THREAD_COUNT + 1),
  localparam int unsigned TOT_W   = $clog2(THREAD_COUNT * ((1 << WEIGHT_BITS) - 1) + 1),
  localparam int unsigned IN_RAW  = RND_W + TID_W + THREAD_COUNT,
  localparam int unsigned IN_DW   = ((IN_RAW + 7) / 8) * 8,
  localparam int unsigned OUT_RAW = CH_W + TOT_W + 1 + THREAD_COUNT,
  localparam int unsigned OUT_DW  = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write port
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [PACK_W-1:0] cfg_wdata_i,
  // Command stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // random_value, thread_id, new_mask
  input  logic [IN_DW-1:0]  s_axis_tdata,
  // cmd
  input  logic [CMD_W-1:0]  s_axis_tuser,
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // chosen_thread, drawn_ticket, all_retired, active_now
  output logic [OUT_DW-1:0] m_axis_tdata
);

  state_e state_q, state_d;

  logic [PACK_W-1:0]       tickets_q, prios_q;
  logic [THREAD_COUNT-1:0] mask_q;
  cmd_e                    cmd_q;
  logic [CH_W-1:0]         chosen_q;
  logic [TOT_W-1:0]        ticket_q;
  logic                    m_tvalid_q;
  logic [OUT_DW-1:0]       m_tdata_q;

  logic [THREAD_COUNT-1:0][WEIGHT_BITS-1:0] tick_f, prio_f;
  logic [TOT_W-1:0]        total;
  cmd_e                    in_cmd;
  logic [RND_W-1:0]        in_rnd;
  logic [TID_W-1:0]        in_tid;
  logic [THREAD_COUNT-1:0] in_mask;
  logic                    accept, out_load, div_start, div_done, scan_done;
  logic [TOT_W-1:0]        div_rem;
  logic [CH_W-1:0]         scan_chosen;
  scan_ctl_t               scan_ctl;

  // Input unpacking
  assign in_cmd  = cmd_e'(s_axis_tuser);
  assign in_rnd  = s_axis_tdata[RND_W-1:0];
  assign in_tid  = s_axis_tdata[RND_W +: TID_W];
  assign in_mask = s_axis_tdata[RND_W + TID_W +: THREAD_COUNT];
  assign accept  = s_axis_tvalid && s_axis_tready;

  // Per-thread fields; a field starting at or past the limit reads as zero
  always_comb begin
    for (int i = 0; i < THREAD_COUNT; i++) begin
      if (i * WEIGHT_BITS < FIELD_LIMIT) begin
        tick_f[i] = tickets_q[i*WEIGHT_BITS +: WEIGHT_BITS];
        prio_f[i] = prios_q[i*WEIGHT_BITS +: WEIGHT_BITS];
      end else begin
        tick_f[i] = '0;
        prio_f[i] = '0;
      end
    end
  end

  // Ticket total of the active threads
  always_comb begin
    total = '0;
    for (int i = 0; i < THREAD_COUNT; i++) begin
      if (mask_q[i]) begin
        total = total + TOT_W'(tick_f[i]);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_LOTTERY:  state_d = (total == '0) ? ST_OUT : ST_DIV;
            CMD_PRIORITY: state_d = ST_SCAN;
            default:      state_d = ST_OUT;
          endcase
        end
      end
      ST_DIV:  if (div_done) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_OUT;
      ST_OUT:  if (!m_tvalid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready    = (state_q == ST_IDLE);
    div_start        = accept && (in_cmd == CMD_LOTTERY) && (total != '0);
    scan_ctl.start   = (accept && (in_cmd == CMD_PRIORITY)) || (state_q == ST_DIV && div_done);
    scan_ctl.lottery = (state_q == ST_DIV);
    out_load         = (state_q == ST_OUT) && (!m_tvalid_q || m_axis_tready);
  end

  // Control registers: state, configuration, active mask, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tickets_q  <= '0;
      prios_q    <= '0;
      mask_q     <= '1;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_TICKETS:    tickets_q <= cfg_wdata_i;
          CFG_PRIORITIES: prios_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        case (in_cmd)
          CMD_RETIRE: begin
            for (int i = 0; i < THREAD_COUNT; i++) begin
              if (in_tid == TID_W'(i + 1)) begin
                mask_q[i] <= 1'b0;
              end
            end
          end
          CMD_LOAD: mask_q <= in_mask;
          default: ;
        endcase
      end
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_cmd;
      chosen_q <= '0;
      ticket_q <= '0;
    end else if (state_q == ST_DIV && div_done) begin
      ticket_q <= div_rem + TOT_W'(1);
    end else if (scan_done) begin
      chosen_q <= scan_chosen;
    end
    if (out_load) begin
      m_tdata_q <= OUT_DW'({mask_q, (mask_q == '0), ticket_q, chosen_q});
    end
  end

  // Remainder of the random value by the ticket total
  lpt_serial_mod #(
    .TOT_W (TOT_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_rnd),
    .divisor_i  (total),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Thread scan for both pick kinds
  lpt_thread_scan #(
    .THREAD_COUNT (THREAD_COUNT),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .TOT_W        (TOT_W),
    .CH_W         (CH_W)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .mask_i    (mask_q),
    .weights_i ((cmd_q == CMD_LOTTERY) ? tick_f : prio_f),
    .ticket_i  (ticket_q),
    .done_o    (scan_done),
    .chosen_o  (scan_chosen)
  );

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule
